### src/upd_pkg.sv
// ----------------------------------------------------------------------------
// URL percent decoder package
// Shared types, constants and character helpers for the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

	// Escape introducer character.
	localparam logic [7:0] PERCENT_CHAR = 8'h25;

	// Default number of entries in the queue between front and back.
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// Escape tracking phase of the front end.
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	// One classified input word: up to three output bytes and a last flag.
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] cnt;
		logic       last;
	} upd_entry_t;

	// True for 0-9, a-f and A-F.
	function automatic logic is_hex(input logic [7:0] b);
		is_hex = ((b >= 8'h30) && (b <= 8'h39)) ||
			((b >= 8'h61) && (b <= 8'h66)) ||
			((b >= 8'h41) && (b <= 8'h46));
	endfunction

	// Nibble value of a hex character; zero for anything else.
	function automatic logic [3:0] hex_value(input logic [7:0] b);
		logic [7:0] v;
		v = 8'h00;
		if ((b >= 8'h30) && (b <= 8'h39)) begin
			v = b - 8'h30;
		end else if ((b >= 8'h61) && (b <= 8'h66)) begin
			v = b - 8'h57;
		end else if ((b >= 8'h41) && (b <= 8'h46)) begin
			v = b - 8'h37;
		end
		hex_value = v[3:0];
	endfunction

endpackage

`default_nettype wire

### src/upd_front.sv
// ----------------------------------------------------------------------------
// URL percent decoder front end
// Accepts raw bytes, tracks escape state and turns each input word into a
// queue entry holding the zero to three bytes that it produces.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         in_byte,
	input  wire logic               in_last,
	input  wire logic               q_full,
	output logic                    push,
	output upd_pkg::upd_entry_t     push_data
);
	import upd_pkg::*;

	phase_t     phase_q;
	phase_t     phase_d;
	logic [7:0] held_q;
	logic [7:0] held_d;
	logic       accept;
	logic       b_hex;
	logic       b_pct;
	logic [7:0] s0;
	logic [7:0] s1;
	logic [7:0] s2;
	logic [1:0] n;

	// A word is taken whenever the queue has room.
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign b_hex    = is_hex(in_byte);
	assign b_pct    = (in_byte == PERCENT_CHAR);

	// Classify the word against the pending escape, then flush on last.
	always_comb begin
		phase_d = phase_q;
		held_d  = held_q;
		s0      = 8'h00;
		s1      = 8'h00;
		s2      = 8'h00;
		n       = 2'd0;
		case (phase_q)
			PH_PCT: begin
				if (b_hex) begin
					phase_d = PH_DIGIT;
					held_d  = in_byte;
				end else if (b_pct) begin
					s0      = PERCENT_CHAR;
					n       = 2'd1;
					phase_d = PH_PCT;
				end else begin
					s0      = PERCENT_CHAR;
					s1      = in_byte;
					n       = 2'd2;
					phase_d = PH_IDLE;
				end
			end
			PH_DIGIT: begin
				if (b_hex) begin
					s0      = {hex_value(held_q), hex_value(in_byte)};
					n       = 2'd1;
					phase_d = PH_IDLE;
				end else if (b_pct) begin
					s0      = PERCENT_CHAR;
					s1      = held_q;
					n       = 2'd2;
					phase_d = PH_PCT;
				end else begin
					s0      = PERCENT_CHAR;
					s1      = held_q;
					s2      = in_byte;
					n       = 2'd3;
					phase_d = PH_IDLE;
				end
			end
			default: begin
				if (b_pct) begin
					phase_d = PH_PCT;
				end else begin
					s0      = in_byte;
					n       = 2'd1;
					phase_d = PH_IDLE;
				end
			end
		endcase

		// On the last word, pending characters come out as plain bytes.
		if (in_last) begin
			if (phase_d == PH_PCT) begin
				case (n)
					2'd0: s0 = PERCENT_CHAR;
					2'd1: s1 = PERCENT_CHAR;
					default: s2 = PERCENT_CHAR;
				endcase
				n = n + 2'd1;
			end else if (phase_d == PH_DIGIT) begin
				s0 = PERCENT_CHAR;
				s1 = held_d;
				n  = 2'd2;
			end
			phase_d = PH_IDLE;
			held_d  = 8'h00;
		end
	end

	// Queue entry for this word; words that produce nothing are dropped.
	always_comb begin
		push           = accept && (n != 2'd0);
		push_data.b0   = s0;
		push_data.b1   = s1;
		push_data.b2   = s2;
		push_data.cnt  = n;
		push_data.last = in_last;
	end

	// Escape state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'h00;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule

`default_nettype wire

### src/upd_queue.sv
// ----------------------------------------------------------------------------
// URL percent decoder entry queue
// Small first-in first-out queue that decouples the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_queue #(
	parameter int DEPTH = upd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire upd_pkg::upd_entry_t push_data,
	output logic                     full,
	input  wire logic                pop,
	output upd_pkg::upd_entry_t      head,
	output logic                     not_empty
);
	import upd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	upd_entry_t     entries_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### src/upd_back.sv
// ----------------------------------------------------------------------------
// URL percent decoder back end
// Walks the bytes of the head queue entry one per cycle, while out_stall is low, into the output
// register, marking the final byte of a string.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire upd_pkg::upd_entry_t head,
	input  wire logic                head_valid,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [7:0]               out_byte,
	output logic                     out_last
);
	import upd_pkg::*;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic [1:0] idx_q;
	logic [1:0] idx_inc;
	logic       load;
	logic       take;
	logic       final_byte;
	logic [7:0] sel_byte;

	// The output register refills when empty or when its word is taken.
	assign load       = !out_valid_q || !out_stall;
	assign take       = load && head_valid;
	assign idx_inc    = idx_q + 2'd1;
	assign final_byte = (idx_inc == head.cnt);
	assign pop        = take && final_byte;

	// Pick the current byte of the head entry.
	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.b0;
			2'd1:    sel_byte = head.b1;
			default: sel_byte = head.b2;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= head_valid;
			end
			if (take) begin
				idx_q <= final_byte ? 2'd0 : idx_inc;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q <= sel_byte;
			out_last_q <= head.last && final_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

### src/url_percent_decoder.sv
// An accepted byte passes through the entry queue and then the output register.
// Throughput: one input byte per cycle while each byte yields at most one word and out_stall is low;
// the output side delivers one word per cycle while out_stall is low, so escapes that expand stall the input.
// The entry queue (QUEUE_DEPTH entries) sets how long the front runs ahead of the output.
// Reset (arst_n low, asynchronous) empties the queue and clears any pending escape.
// ----------------------------------------------------------------------------
// URL percent decoder
// Streaming decoder of %XX escapes with a decoupled front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_decoder #(
	parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            out_last
);
	import upd_pkg::*;

	upd_entry_t push_data;
	upd_entry_t head;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_not_empty;

	// Front end: escape tracking and classification.
	upd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// Queue between the two ends.
	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.not_empty (q_not_empty)
	);

	// Back end: byte serializer and output register.
	upd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (q_not_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.out_last   (out_last)
	);

endmodule

`default_nettype wire
